FILE: sv/mf_pkg.sv
// ----------------------------------------------------------------------------
// mf_pkg
// Shared widths, codes and queue entry type of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int COL_W      = ADDR_W;
  localparam int ROW_W      = 12;
  localparam int PEND_W     = 11;
  localparam int CFG_DATA_W = 12;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  // Register indexes of the configuration port.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // What the back end does with an item.
  typedef enum logic [1:0] {
    SEL_NONE = 2'b00,  // no result, window update only
    SEL_W5   = 2'b01,  // pass the middle-right window pixel
    SEL_MED  = 2'b10,  // median of the updated window
    SEL_RAW  = 2'b11   // pass the line store read data
  } sel_e;

  typedef struct packed {
    logic             is_pixel;
    sel_e             sel;
    logic             last;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] pix;
  } q_entry_t;

endpackage

FILE: sv/mf_line_buf.sv
// ----------------------------------------------------------------------------
// mf_line_buf
// Two line stores with one shared registered read port and one write each.
// ----------------------------------------------------------------------------
module mf_line_buf (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [mf_pkg::ADDR_W-1:0]   addr_i,
  input  logic                        wr_a_en_i,
  input  logic [mf_pkg::PIX_W-1:0]    wr_a_data_i,
  input  logic                        wr_b_en_i,
  input  logic [mf_pkg::ADDR_W-1:0]   wr_b_addr_i,
  input  logic [mf_pkg::PIX_W-1:0]    wr_b_data_i,
  output logic [mf_pkg::PIX_W-1:0]    rd_a_o,
  output logic [mf_pkg::PIX_W-1:0]    rd_b_o
);
  import mf_pkg::*;

  logic [PIX_W-1:0] store_a [MAX_WIDTH];
  logic [PIX_W-1:0] store_b [MAX_WIDTH];
  logic [PIX_W-1:0] rd_a_q;
  logic [PIX_W-1:0] rd_b_q;

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= store_a[addr_i];
    end
    if (wr_a_en_i) begin
      store_a[addr_i] <= wr_a_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_b_q <= store_b[addr_i];
    end
    if (wr_b_en_i) begin
      store_b[wr_b_addr_i] <= wr_b_data_i;
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

FILE: sv/mf_front.sv
// ----------------------------------------------------------------------------
// mf_front
// Configuration registers, raster counters and item classification; issues
// the line store access and queues one entry per pixel or pending drain item.
// ----------------------------------------------------------------------------
module mf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [mf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [mf_pkg::PIX_W-1:0]       pixel_in_i,
  input  logic [mf_pkg::Q_CNT_W-1:0]     q_count_i,
  output logic                           push_o,
  output mf_pkg::q_entry_t               push_entry_o
);
  import mf_pkg::*;

  typedef struct packed {
    logic              is_pixel;
    sel_e              sel;
    logic              last;
    logic [PIX_W-1:0]  pix;
    logic [ADDR_W-1:0] addr;
  } desc_t;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [COL_W-1:0]    c_q, c_d;
  logic [ROW_W-1:0]    r_q, r_d;
  logic [PEND_W-1:0]   pend_q, pend_d;
  logic                s1_valid_q, s1_valid_d;
  desc_t               s1_q, s1_d;
  logic                accept;
  logic                border;
  logic [ADDR_W-1:0]   rd_addr;
  logic [PIX_W-1:0]    rd_a;
  logic [PIX_W-1:0]    rd_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WIDTH_W'(3)) begin
      w_eff = WIDTH_W'(3);
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_q;
  end

  // Room in the queue must cover the entry still in the access stage.
  assign in_ready_o = ((Q_CNT_W + 1)'(q_count_i) + (Q_CNT_W + 1)'(s1_valid_q))
                      < (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  assign border = (r_q == ROW_W'(1)) || (c_q == COL_W'(1)) ||
                  ((WIDTH_W)'(c_q) >= w_eff) || (r_q >= h_eff);

  always_comb begin
    c_d        = c_q;
    r_d        = r_q;
    pend_d     = pend_q;
    s1_valid_d = 1'b0;
    s1_d       = '0;
    rd_addr    = c_q;
    if (accept) begin
      if (action_i) begin
        if (pend_q != '0) begin
          s1_valid_d  = 1'b1;
          s1_d.last   = (pend_q == PEND_W'(1));
          s1_d.sel    = (pend_q >= PEND_W'(w_eff + WIDTH_W'(1))) ? SEL_W5 : SEL_RAW;
          rd_addr     = ADDR_W'(w_eff - WIDTH_W'(pend_q));
          s1_d.addr   = rd_addr;
          pend_d      = pend_q - PEND_W'(1);
        end
      end else begin
        s1_valid_d    = 1'b1;
        s1_d.is_pixel = 1'b1;
        s1_d.pix      = pixel_in_i;
        s1_d.addr     = c_q;
        pend_d        = '0;
        if ((c_q != '0) && (r_q != '0)) begin
          s1_d.sel = border ? SEL_W5 : SEL_MED;
        end else if ((c_q == '0) && (r_q >= ROW_W'(2))) begin
          s1_d.sel = SEL_W5;
        end else begin
          s1_d.sel = SEL_NONE;
        end
        if (((COL_W + 1)'(c_q) + (COL_W + 1)'(1)) >= (COL_W + 1)'(w_eff)) begin
          c_d = '0;
          if (((ROW_W + 1)'(r_q) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(h_eff)) begin
            r_d    = '0;
            pend_d = PEND_W'(w_eff + WIDTH_W'(1));
          end else begin
            r_d = r_q + ROW_W'(1);
          end
        end else begin
          c_d = c_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q        <= '0;
      r_q        <= '0;
      pend_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      c_q        <= c_d;
      r_q        <= r_d;
      pend_q     <= pend_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // The older row moves into line store b in the following cycle, once its read
  // data is back.
  mf_line_buf u_line_buf (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .addr_i      (rd_addr),
    .wr_a_en_i   (accept && !action_i),
    .wr_a_data_i (pixel_in_i),
    .wr_b_en_i   (s1_valid_q && s1_q.is_pixel),
    .wr_b_addr_i (s1_q.addr),
    .wr_b_data_i (rd_a),
    .rd_a_o      (rd_a),
    .rd_b_o      (rd_b)
  );

  assign push_o                = s1_valid_q;
  assign push_entry_o.is_pixel = s1_q.is_pixel;
  assign push_entry_o.sel      = s1_q.sel;
  assign push_entry_o.last     = s1_q.last;
  assign push_entry_o.top      = rd_b;
  assign push_entry_o.mid      = rd_a;
  assign push_entry_o.pix      = s1_q.pix;

endmodule

FILE: sv/mf_queue.sv
// ----------------------------------------------------------------------------
// mf_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module mf_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mf_pkg::q_entry_t            push_entry_i,
  input  logic                        pop_i,
  output logic                        not_empty_o,
  output mf_pkg::q_entry_t            head_o,
  output logic [mf_pkg::Q_CNT_W-1:0]  count_o
);
  import mf_pkg::*;

  q_entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q;
  logic [Q_PTR_W-1:0]   rd_ptr_q;
  logic [Q_CNT_W-1:0]   count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + Q_CNT_W'(1);
        2'b01:   count_q <= count_q - Q_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign count_o     = count_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && (count_q == Q_CNT_W'(Q_DEPTH))))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

FILE: sv/mf_back.sv
// ----------------------------------------------------------------------------
// mf_back
// 3x3 window of sorted columns, two-stage median and the output register.
// ----------------------------------------------------------------------------
module mf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  mf_pkg::q_entry_t          q_entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mf_pkg::PIX_W-1:0]  pixel_out_o,
  output logic                      frame_last_o
);
  import mf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } col_t;

  function automatic logic [PIX_W-1:0] min2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                            logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                 logic [PIX_W-1:0] c);
    col_t             s;
    logic [PIX_W-1:0] lo1;
    logic [PIX_W-1:0] hi1;
    logic [PIX_W-1:0] t;
    lo1  = min2(a, b);
    hi1  = max2(a, b);
    s.hi = max2(hi1, c);
    t    = min2(hi1, c);
    s.lo = min2(lo1, t);
    s.md = max2(lo1, t);
    return s;
  endfunction

  col_t              col_q [3];
  logic [PIX_W-1:0]  w5_q;
  logic              adv;

  logic              s1_valid_q;
  sel_e              s1_sel_q;
  logic              s1_last_q;
  logic [PIX_W-1:0]  s1_pass_q;

  logic              s2_valid_q;
  sel_e              s2_sel_q;
  logic              s2_last_q;
  logic [PIX_W-1:0]  s2_pass_q;
  logic [PIX_W-1:0]  s2_lo_q;
  logic [PIX_W-1:0]  s2_md_q;
  logic [PIX_W-1:0]  s2_hi_q;

  logic              out_valid_q;
  logic [PIX_W-1:0]  out_pixel_q, out_pixel_d;
  logic              out_last_q;

  // The whole back pipeline moves together whenever the output can move.
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        col_q[i] <= '0;
      end
      w5_q <= '0;
    end else if (pop_o && q_entry_i.is_pixel) begin
      col_q[0] <= col_q[1];
      col_q[1] <= col_q[2];
      col_q[2] <= sort3(q_entry_i.top, q_entry_i.mid, q_entry_i.pix);
      w5_q     <= q_entry_i.mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pop_o && (q_entry_i.sel != SEL_NONE);
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_comb begin
    case (s2_sel_q)
      SEL_MED: out_pixel_d = med3(s2_lo_q, s2_md_q, s2_hi_q);
      default: out_pixel_d = s2_pass_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sel_q    <= q_entry_i.sel;
      s1_last_q   <= q_entry_i.last;
      s1_pass_q   <= (q_entry_i.sel == SEL_RAW) ? q_entry_i.mid : w5_q;
      s2_sel_q    <= s1_sel_q;
      s2_last_q   <= s1_last_q;
      s2_pass_q   <= s1_pass_q;
      s2_lo_q     <= max2(max2(col_q[0].lo, col_q[1].lo), col_q[2].lo);
      s2_md_q     <= med3(col_q[0].md, col_q[1].md, col_q[2].md);
      s2_hi_q     <= min2(min2(col_q[0].hi, col_q[1].hi), col_q[2].hi);
      out_pixel_q <= out_pixel_d;
      out_last_q  <= s2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = out_pixel_q;
  assign frame_last_o = out_last_q;

`ifndef SYNTHESIS
  a_s1_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_sel_q != SEL_NONE))
    else $error("result stage holds an item without a result");

  a_window_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(w5_q) && $stable(col_q[2])))
    else $error("window moved while the output stalled");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(s1_valid_q) && $stable(s2_valid_q)))
    else $error("median pipeline moved while the output stalled");
`endif

endmodule

FILE: sv/median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// 3x3 median filter over an 8-bit raster stream with border pass-through.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------
// cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o   action_i, pixel_in_i
// out       out        out_valid_o / out_ready_i pixel_out_o, frame_last_o
//
// One item is accepted per clock when the output keeps flowing; the rate is
// set by the single read port of each line store, which serves one pixel a cycle.
// A result passes through the line store access, the queue, the window update,
// the median stage and the output register, plus any time waiting in the queue.
// Reset clears counters, window and queue at once; line stores are not cleared.
// The four-entry queue lets the input keep going while the output stalls;
// in_ready_o drops once the queue and the access stage together hold four items.
// ----------------------------------------------------------------------------
module median_filter_3x3_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [mf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [mf_pkg::PIX_W-1:0]       pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mf_pkg::PIX_W-1:0]       pixel_out_o,
  output logic                           frame_last_o
);
  import mf_pkg::*;

  logic                push;
  q_entry_t            push_entry;
  logic                pop;
  logic                q_not_empty;
  q_entry_t            q_head;
  logic [Q_CNT_W-1:0]  q_count;

  // The front end owns the configuration registers, the raster counters and
  // the line stores. Every pixel item and every drain item that still has a
  // result pending turns into one queue entry carrying its classification
  // and the pixels read from the line stores.
  mf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .pixel_in_i   (pixel_in_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // The queue decouples the two sides, so an output stall does not reach the
  // input until it has filled.
  mf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .not_empty_o  (q_not_empty),
    .head_o       (q_head),
    .count_o      (q_count)
  );

  // The back end holds the window as three sorted columns, so only the newest
  // column is sorted as a pixel arrives; the median then takes two further
  // compare stages before it reaches the output register.
  mf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_not_empty),
    .q_entry_i    (q_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams grayscale frames through the 3x3 median filter and checks every
// filtered pixel against a cycle-free model of the filter kept in this file.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mf_pkg::*;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam int          SETTLE_CYCLES  = 16;
  localparam int          RANDOM_ITEMS   = 300;
  localparam longint      TIMEOUT_NS     = 64'd10_000_000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } filtered_pixel_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i  = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic                  action_i     = ACT_PIXEL;
  logic [PIX_W-1:0]      pixel_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  frame_last_o;

  median_filter_3x3_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

  always #4 clk_i = ~clk_i;

  // Filter state as seen from outside: the previous row, the row before it,
  // the 3x3 window and the raster position of the next pixel.
  logic [PIX_W-1:0]    last_row_px  [MAX_WIDTH];
  logic [PIX_W-1:0]    older_row_px [MAX_WIDTH];
  logic [PIX_W-1:0]    win_px       [9];
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int unsigned         col_pos;
  int unsigned         row_pos;
  int unsigned         pend_cnt;

  filtered_pixel_t expected_pixels_q [$];
  int unsigned     mismatch_cnt;
  int unsigned     items_accepted_cnt;
  bit              idle_on;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < HEIGHT_W'(3)) ? 3 : 32'(height_reg);
  endfunction

  function automatic logic [PIX_W-1:0] window_median();
    logic [8:0][PIX_W-1:0] s;
    logic [PIX_W-1:0]      x;
    int                    j;
    for (int i = 0; i < 9; i++) s[i] = win_px[i];
    for (int i = 1; i < 9; i++) begin
      x = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > x) begin
        s[j+1] = s[j];
        j--;
      end
      s[j+1] = x;
    end
    return s[4];
  endfunction

  // Advances the filter state by one item and tells whether it releases a
  // pixel, and which one.
  function automatic void filter_step(input logic act, input logic [PIX_W-1:0] pix,
                                      output bit produced,
                                      output logic [PIX_W-1:0] res_pix,
                                      output logic res_last);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int unsigned      idx;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    bit               border;
    w        = eff_width();
    h        = eff_height();
    c        = col_pos;
    r        = row_pos;
    produced = 1'b0;
    res_pix  = '0;
    res_last = 1'b0;

    if (act == ACT_DRAIN) begin
      if (pend_cnt == 0) return;
      // The first drain, and the surplus drains after a width shrink, repeat the window pixel.
      if (pend_cnt >= w + 1) res_pix = win_px[5];
      else res_pix = last_row_px[(w - pend_cnt) % MAX_WIDTH];
      res_last = (pend_cnt == 1);
      produced = 1'b1;
      pend_cnt--;
      return;
    end

    // A new pixel abandons whatever the previous frame still had pending.
    pend_cnt = 0;

    // The right-border pixel two rows up leaves when a row starts.
    if (c == 0 && r >= 2) begin
      res_pix  = win_px[5];
      produced = 1'b1;
    end

    idx               = c % MAX_WIDTH;
    top               = older_row_px[idx];
    mid               = last_row_px[idx];
    older_row_px[idx] = mid;
    last_row_px[idx]  = pix;
    for (int i = 0; i < 3; i++) begin
      win_px[i*3]   = win_px[i*3+1];
      win_px[i*3+1] = win_px[i*3+2];
    end
    win_px[2] = top;
    win_px[5] = mid;
    win_px[8] = pix;

    if (c >= 1 && r >= 1) begin
      border   = (r == 1) || (c == 1) || (c >= w) || (r >= h);
      res_pix  = border ? win_px[4] : window_median();
      produced = 1'b1;
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      if (r + 1 >= h) begin
        row_pos  = 0;
        pend_cnt = w + 1;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] p;
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = '1;
      2: p = PIX_W'(120 + $urandom_range(0, 3));
      default: p = PIX_W'($urandom_range(0, 255));
    endcase
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Sends one item, holding valid and payload until the block accepts it.
  task automatic send_item(input logic act, input logic [PIX_W-1:0] pix);
    int unsigned      gap;
    bit               produced;
    logic [PIX_W-1:0] res_pix;
    logic             res_last;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    filter_step(act, pix, produced, res_pix, res_last);
    if (produced) expected_pixels_q.push_back('{pixel: res_pix, last: res_last});
    if (act == ACT_PIXEL || produced) items_accepted_cnt++;
  endtask

  // Stops the stream and waits until every expected pixel is out and the
  // pipeline has had time to finish items that release nothing.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_pixels_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic update_frame_size(input logic [CFG_DATA_W-1:0] width_value,
                                   input logic [CFG_DATA_W-1:0] height_value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_data_i  <= width_value;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_reg   = width_value[WIDTH_W-1:0];
    cfg_index_i <= CFG_IMAGE_HEIGHT;
    cfg_data_i  <= height_value;
    do @(posedge clk_i); while (!cfg_ready_o);
    height_reg  = height_value[HEIGHT_W-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  // Sends pixels until the raster position wraps to the start of a frame.
  task automatic finish_frame();
    do send_item(ACT_PIXEL, random_pixel()); while (!(col_pos == 0 && row_pos == 0));
  endtask

  task automatic drain_pending();
    while (pend_cnt != 0) send_item(ACT_DRAIN, random_pixel());
  endtask

  // Right after reset the default width is in force; a shrink in the middle
  // of the first row wraps the column counter.
  task automatic test_reset_defaults();
    repeat (6) send_item(ACT_PIXEL, random_pixel());
    settle_block();
    update_frame_size(12'd4, 12'd4);
    finish_frame();
    drain_pending();
  endtask

  // All-ones and zero register values, clamped by the block, changed while
  // a frame is under way.
  task automatic test_register_extremes();
    settle_block();
    update_frame_size('1, 12'd4095);
    send_item(ACT_PIXEL, '0);
    send_item(ACT_PIXEL, '1);
    repeat (8) send_item(ACT_PIXEL, random_pixel());
    settle_block();
    update_frame_size('0, 12'd4095);
    repeat (12) send_item(ACT_PIXEL, random_pixel());
    settle_block();
    update_frame_size('0, '0);
    finish_frame();
    drain_pending();
    send_item(ACT_DRAIN, '1);
  endtask

  // Drains after a width shrink, a drain with nothing left, and a new frame
  // that cuts the previous frame's drain short.
  task automatic test_drain_corners();
    settle_block();
    update_frame_size(12'd6, 12'd3);
    finish_frame();
    settle_block();
    update_frame_size(12'd3, 12'd3);
    drain_pending();
    send_item(ACT_DRAIN, '0);
    finish_frame();
    repeat (2) send_item(ACT_DRAIN, random_pixel());
    finish_frame();
    drain_pending();
  endtask

  // Back-to-back frames with both sides always ready.
  task automatic test_full_rate();
    settle_block();
    idle_on = 1'b0;
    update_frame_size(12'd5, 12'd4);
    repeat (3) begin
      finish_frame();
      drain_pending();
    end
    idle_on = 1'b1;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_width();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom_range(0, 2));
      1: return CFG_DATA_W'($urandom_range(13, 64));
      default: return CFG_DATA_W'($urandom_range(3, 12));
    endcase
  endfunction

  task automatic test_random_frames();
    int unsigned first_item;
    int unsigned shape;
    int unsigned head;
    first_item = items_accepted_cnt;
    while (items_accepted_cnt - first_item < RANDOM_ITEMS) begin
      settle_block();
      update_frame_size(random_width(), CFG_DATA_W'($urandom_range(0, 7)));
      idle_on = ($urandom_range(0, 3) != 0);
      shape   = $urandom_range(0, 9);
      // Stray drains are harmless only when nothing is pending.
      if (pend_cnt == 0 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) send_item(ACT_DRAIN, random_pixel());
      if (shape == 0) begin
        // Resize in the middle of the frame: the width only shrinks, so no
        // window ever sees a line store entry from before this frame.
        head = $urandom_range(1, eff_width() * eff_height() - 1);
        repeat (head) send_item(ACT_PIXEL, random_pixel());
        settle_block();
        update_frame_size(CFG_DATA_W'($urandom_range(3, eff_width())),
                          CFG_DATA_W'($urandom_range(0, 7)));
      end
      finish_frame();
      if (shape == 1) begin
        repeat ($urandom_range(1, pend_cnt - 1)) send_item(ACT_DRAIN, random_pixel());
      end else if (shape == 2) begin
        settle_block();
        update_frame_size(CFG_DATA_W'($urandom_range(3, eff_width())), height_reg);
        drain_pending();
      end else begin
        drain_pending();
        if ($urandom_range(0, 4) == 0) send_item(ACT_DRAIN, random_pixel());
      end
    end
  endtask

  // Result side: a random stall before each item, none at full rate.
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels_q.size() == 0) begin
        report_mismatch("unexpected pixel", 0, pixel_out_o);
      end else begin
        if (pixel_out_o !== expected_pixels_q[0].pixel)
          report_mismatch("pixel_out", expected_pixels_q[0].pixel, pixel_out_o);
        if (frame_last_o !== expected_pixels_q[0].last)
          report_mismatch("frame_last", expected_pixels_q[0].last, frame_last_o);
        void'(expected_pixels_q.pop_front());
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      last_row_px[i]  = '0;
      older_row_px[i] = '0;
    end
    for (int i = 0; i < 9; i++) win_px[i] = '0;
    width_reg          = WIDTH_RESET;
    height_reg         = HEIGHT_RESET;
    col_pos            = 0;
    row_pos            = 0;
    pend_cnt           = 0;
    mismatch_cnt       = 0;
    items_accepted_cnt = 0;
    idle_on            = 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_drain_corners();
    test_full_rate();
    test_random_frames();

    in_valid_i <= 1'b0;
    while (expected_pixels_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
